@@ design/scf_pkg.sv @@
// Shared constants and types for the segment pair crossing block.
package scf_pkg;

  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int DIR_W    = COORD_W + 1;
  localparam int PROD_W   = 2 * DIR_W;
  localparam int DEN_W    = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int QUOT_W   = 32;
  localparam int MARGIN_W = 15;
  localparam int THR_W    = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 1;
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = QPTR_W + 1;
  localparam int SUM_W    = COORD_W + 3;
  localparam int MUL_W    = DIR_W + QUOT_W;

  localparam logic [IDX_W-1:0] REG_END_MARGIN = 1'b0;
  localparam logic [IDX_W-1:0] REG_PAR_THR    = 1'b1;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = 15'd1311;
  localparam logic [THR_W-1:0]    THR_RST    = 32'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [DIR_W-1:0]   dir_ax;
    logic signed [DIR_W-1:0]   dir_ay;
    logic signed [DIR_W-1:0]   dir_bx;
    logic signed [DIR_W-1:0]   dir_by;
    logic [MAG_W-1:0]          den;
    logic [MAG_W-1:0]          tn;
    logic [MAG_W-1:0]          un;
    logic                      ok;
  } entry_t;

  typedef struct packed {
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

@@ design/scf_front.sv @@
// Front part: directions, cross products, denominator and range classification.
module scf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [scf_pkg::COORD_W-1:0] a_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0] a_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0] a_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0] a_end_y,
  input  logic signed [scf_pkg::COORD_W-1:0] b_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0] b_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0] b_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0] b_end_y,
  input  logic [scf_pkg::THR_W-1:0]        thr,
  input  scf_pkg::qstat_t                  qstat,
  output logic                             push,
  output scf_pkg::entry_t                  push_data
);

  logic v1, v2, v3;
  logic signed [scf_pkg::COORD_W-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic signed [scf_pkg::DIR_W-1:0] dax1, day1, dbx1, dby1, ox1, oy1;
  logic signed [scf_pkg::DIR_W-1:0] dax2, day2, dbx2, dby2;
  logic signed [scf_pkg::DIR_W-1:0] dax3, day3, dbx3, dby3;
  logic signed [scf_pkg::PROD_W-1:0] p_ad, p_bc, p_t1, p_t2, p_u1, p_u2;
  logic signed [scf_pkg::DEN_W-1:0] den3, tn3, un3;
  logic signed [scf_pkg::DEN_W-1:0] den_n, tn_n, un_n;
  logic [2:0] infl;
  logic [scf_pkg::QCNT_W:0] occ;
  logic take;

  assign infl     = 3'(v1) + 3'(v2) + 3'(v3);
  assign occ      = (scf_pkg::QCNT_W+1)'(qstat.count) + (scf_pkg::QCNT_W+1)'(infl);
  assign in_stall = occ >= (scf_pkg::QCNT_W+1)'(scf_pkg::QDEPTH);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ax1  <= a_start_x;
    ay1  <= a_start_y;
    dax1 <= scf_pkg::DIR_W'(a_end_x) - scf_pkg::DIR_W'(a_start_x);
    day1 <= scf_pkg::DIR_W'(a_end_y) - scf_pkg::DIR_W'(a_start_y);
    dbx1 <= scf_pkg::DIR_W'(b_end_x) - scf_pkg::DIR_W'(b_start_x);
    dby1 <= scf_pkg::DIR_W'(b_end_y) - scf_pkg::DIR_W'(b_start_y);
    ox1  <= scf_pkg::DIR_W'(b_start_x) - scf_pkg::DIR_W'(a_start_x);
    oy1  <= scf_pkg::DIR_W'(b_start_y) - scf_pkg::DIR_W'(a_start_y);

    ax2  <= ax1;
    ay2  <= ay1;
    dax2 <= dax1;
    day2 <= day1;
    dbx2 <= dbx1;
    dby2 <= dby1;
    p_ad <= scf_pkg::PROD_W'(dax1) * scf_pkg::PROD_W'(dby1);
    p_bc <= scf_pkg::PROD_W'(day1) * scf_pkg::PROD_W'(dbx1);
    p_t1 <= scf_pkg::PROD_W'(ox1) * scf_pkg::PROD_W'(dby1);
    p_t2 <= scf_pkg::PROD_W'(oy1) * scf_pkg::PROD_W'(dbx1);
    p_u1 <= scf_pkg::PROD_W'(ox1) * scf_pkg::PROD_W'(day1);
    p_u2 <= scf_pkg::PROD_W'(oy1) * scf_pkg::PROD_W'(dax1);

    ax3  <= ax2;
    ay3  <= ay2;
    dax3 <= dax2;
    day3 <= day2;
    dbx3 <= dbx2;
    dby3 <= dby2;
    den3 <= scf_pkg::DEN_W'(p_ad) - scf_pkg::DEN_W'(p_bc);
    tn3  <= scf_pkg::DEN_W'(p_t1) - scf_pkg::DEN_W'(p_t2);
    un3  <= scf_pkg::DEN_W'(p_u1) - scf_pkg::DEN_W'(p_u2);
  end

  always_comb begin
    den_n = den3[scf_pkg::DEN_W-1] ? -den3 : den3;
    tn_n  = den3[scf_pkg::DEN_W-1] ? -tn3 : tn3;
    un_n  = den3[scf_pkg::DEN_W-1] ? -un3 : un3;
    push  = v3;
    push_data.start_x = ax3;
    push_data.start_y = ay3;
    push_data.dir_ax  = dax3;
    push_data.dir_ay  = day3;
    push_data.dir_bx  = dbx3;
    push_data.dir_by  = dby3;
    push_data.den     = den_n[scf_pkg::MAG_W-1:0];
    push_data.tn      = tn_n[scf_pkg::MAG_W-1:0];
    push_data.un      = un_n[scf_pkg::MAG_W-1:0];
    push_data.ok      = (den_n != '0)
                     && (den_n >= scf_pkg::DEN_W'(thr))
                     && !tn_n[scf_pkg::DEN_W-1] && (tn_n < den_n)
                     && !un_n[scf_pkg::DEN_W-1] && (un_n < den_n);
  end

endmodule

@@ design/scf_queue.sv @@
// Request queue between the front and back parts.
module scf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scf_pkg::entry_t push_data,
  input  logic            pop,
  output scf_pkg::entry_t head,
  output scf_pkg::qstat_t qstat
);

  scf_pkg::entry_t slots [scf_pkg::QDEPTH];
  logic [scf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [scf_pkg::QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + scf_pkg::QCNT_W'(push) - scf_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign head             = slots[rd_ptr];
  assign qstat.count      = count;
  assign qstat.head_valid = count != '0;

endmodule

@@ design/scf_back.sv @@
// Back part: pipelined fraction dividers, margin test and crossing point.
module scf_back (
  input  logic                               clk,
  input  logic                               rst,
  input  scf_pkg::entry_t                    head,
  input  scf_pkg::qstat_t                    qstat,
  output logic                               pop,
  input  logic [scf_pkg::MARGIN_W-1:0]       margin,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [scf_pkg::COORD_W-1:0] cross_x,
  output logic signed [scf_pkg::COORD_W-1:0] cross_y,
  output logic signed [scf_pkg::DIR_W-1:0]   a_dir_x,
  output logic signed [scf_pkg::DIR_W-1:0]   a_dir_y,
  output logic signed [scf_pkg::DIR_W-1:0]   b_dir_x,
  output logic signed [scf_pkg::DIR_W-1:0]   b_dir_y
);

  localparam int N = scf_pkg::QUOT_W;

  logic en;
  logic            sv [N];
  scf_pkg::entry_t se [N];
  logic [scf_pkg::MAG_W-1:0]  rt [N];
  logic [scf_pkg::MAG_W-1:0]  ru [N];
  logic [scf_pkg::QUOT_W-1:0] qt [N];
  logic [scf_pkg::QUOT_W-1:0] qu [N];
  logic [scf_pkg::MAG_W-1:0]  rt_next [N];
  logic [scf_pkg::MAG_W-1:0]  ru_next [N];
  logic [scf_pkg::QUOT_W-1:0] qt_next [N];
  logic [scf_pkg::QUOT_W-1:0] qu_next [N];

  logic            mv, mhit;
  scf_pkg::entry_t me;
  logic [scf_pkg::MUL_W-1:0] mpx, mpy;

  logic [scf_pkg::QUOT_W:0] lo_lim, hi_lim;
  logic [16:0] one_minus;
  logic hit_next;
  logic [scf_pkg::DIR_W-1:0] magx, magy;
  logic signed [scf_pkg::COORD_W-1:0] cx_next, cy_next;

  function automatic logic signed [scf_pkg::COORD_W-1:0] place(
    input logic signed [scf_pkg::COORD_W-1:0] start,
    input logic signed [scf_pkg::DIR_W-1:0]   dir,
    input logic [scf_pkg::MUL_W-1:0]          p
  );
    logic [scf_pkg::DIR_W-1:0] m;
    logic                      frac;
    logic signed [scf_pkg::SUM_W-1:0] off, v;
    logic signed [scf_pkg::SUM_W-1:0] maxv, minv;
    m    = p[scf_pkg::MUL_W-1:scf_pkg::QUOT_W];
    frac = |p[scf_pkg::QUOT_W-1:0];
    off  = dir[scf_pkg::DIR_W-1] ? -(scf_pkg::SUM_W'(m) + scf_pkg::SUM_W'(frac))
                                 : scf_pkg::SUM_W'(m);
    v    = scf_pkg::SUM_W'(start) + off;
    maxv = scf_pkg::SUM_W'({1'b0, {(scf_pkg::COORD_W-1){1'b1}}});
    minv = -maxv - scf_pkg::SUM_W'(1);
    if (v > maxv) v = maxv;
    if (v < minv) v = minv;
    return v[scf_pkg::COORD_W-1:0];
  endfunction

  assign en  = !(out_valid && out_stall);
  assign pop = en && qstat.head_valid;

  always_comb begin
    logic [scf_pkg::MAG_W-1:0]  r_t, r_u, d;
    logic [scf_pkg::QUOT_W-1:0] p_t, p_u;
    logic [scf_pkg::MAG_W:0]    s_t, s_u;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        r_t = head.tn;
        r_u = head.un;
        d   = head.den;
        p_t = '0;
        p_u = '0;
      end else begin
        r_t = rt[i-1];
        r_u = ru[i-1];
        d   = se[i-1].den;
        p_t = qt[i-1];
        p_u = qu[i-1];
      end
      s_t = {r_t, 1'b0};
      s_u = {r_u, 1'b0};
      if (s_t >= {1'b0, d}) begin
        s_t = s_t - {1'b0, d};
        qt_next[i] = {p_t[scf_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        qt_next[i] = {p_t[scf_pkg::QUOT_W-2:0], 1'b0};
      end
      if (s_u >= {1'b0, d}) begin
        s_u = s_u - {1'b0, d};
        qu_next[i] = {p_u[scf_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        qu_next[i] = {p_u[scf_pkg::QUOT_W-2:0], 1'b0};
      end
      rt_next[i] = s_t[scf_pkg::MAG_W-1:0];
      ru_next[i] = s_u[scf_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    one_minus = 17'd65536 - 17'(margin);
    lo_lim    = (scf_pkg::QUOT_W+1)'({margin, 16'b0});
    hi_lim    = (scf_pkg::QUOT_W+1)'({one_minus, 16'b0});
    hit_next  = se[N-1].ok
             && ({1'b0, qt[N-1]} > lo_lim) && ({1'b0, qt[N-1]} < hi_lim)
             && ({1'b0, qu[N-1]} > lo_lim) && ({1'b0, qu[N-1]} < hi_lim);
    magx = se[N-1].dir_ax[scf_pkg::DIR_W-1] ? -se[N-1].dir_ax : se[N-1].dir_ax;
    magy = se[N-1].dir_ay[scf_pkg::DIR_W-1] ? -se[N-1].dir_ay : se[N-1].dir_ay;
    cx_next = place(me.start_x, me.dir_ax, mpx);
    cy_next = place(me.start_y, me.dir_ay, mpy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) sv[i] <= 1'b0;
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv[0] <= qstat.head_valid;
      for (int i = 1; i < N; i++) sv[i] <= sv[i-1];
      mv        <= sv[N-1];
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se[0] <= head;
      for (int i = 1; i < N; i++) se[i] <= se[i-1];
      for (int i = 0; i < N; i++) begin
        rt[i] <= rt_next[i];
        ru[i] <= ru_next[i];
        qt[i] <= qt_next[i];
        qu[i] <= qu_next[i];
      end
      me   <= se[N-1];
      mhit <= hit_next;
      mpx  <= scf_pkg::MUL_W'(magx) * scf_pkg::MUL_W'(qt[N-1]);
      mpy  <= scf_pkg::MUL_W'(magy) * scf_pkg::MUL_W'(qt[N-1]);
      hit     <= mhit;
      cross_x <= mhit ? cx_next : '0;
      cross_y <= mhit ? cy_next : '0;
      a_dir_x <= me.dir_ax;
      a_dir_y <= me.dir_ay;
      b_dir_x <= me.dir_bx;
      b_dir_y <= me.dir_by;
    end
  end

endmodule

@@ design/segment_pair_crossing.sv @@
// Top level of the segment pair crossing block.
// Takes one segment pair per cycle while in_stall is low and returns one
// result per pair, in order. A pair passes through the front (differences,
// cross products, denominator and classification), waits in an 8-entry
// queue, then through the back divider pipeline (one quotient bit per stage
// for t and u), the crossing multiplier and the output register. An output
// stall while out_valid is high freezes the back part; the front keeps
// taking pairs until the queue credits run out.
module segment_pair_crossing (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [scf_pkg::IDX_W-1:0]          wr_index,
  input  logic [scf_pkg::CFG_W-1:0]          wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [scf_pkg::COORD_W-1:0] a_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0] a_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0] a_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0] a_end_y,
  input  logic signed [scf_pkg::COORD_W-1:0] b_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0] b_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0] b_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0] b_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [scf_pkg::COORD_W-1:0] cross_x,
  output logic signed [scf_pkg::COORD_W-1:0] cross_y,
  output logic signed [scf_pkg::DIR_W-1:0]   a_dir_x,
  output logic signed [scf_pkg::DIR_W-1:0]   a_dir_y,
  output logic signed [scf_pkg::DIR_W-1:0]   b_dir_x,
  output logic signed [scf_pkg::DIR_W-1:0]   b_dir_y
);

  logic [scf_pkg::MARGIN_W-1:0] end_margin;
  logic [scf_pkg::THR_W-1:0]    parallel_threshold;
  logic            push, pop;
  scf_pkg::entry_t push_data, head;
  scf_pkg::qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_margin         <= scf_pkg::MARGIN_RST;
      parallel_threshold <= scf_pkg::THR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        scf_pkg::REG_END_MARGIN: end_margin <= wr_data[scf_pkg::MARGIN_W-1:0];
        scf_pkg::REG_PAR_THR:    parallel_threshold <= wr_data[scf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  scf_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .a_start_x, .a_start_y, .a_end_x, .a_end_y,
    .b_start_x, .b_start_y, .b_end_x, .b_end_y,
    .thr(parallel_threshold), .qstat, .push, .push_data
  );

  scf_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .qstat
  );

  scf_back u_back (
    .clk, .rst, .head, .qstat, .pop, .margin(end_margin),
    .out_valid, .out_stall, .hit, .cross_x, .cross_y,
    .a_dir_x, .a_dir_y, .b_dir_x, .b_dir_y
  );

endmodule

@@ design/scf_checker.sv @@
// Port-level checks for the segment pair crossing block.
module scf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               hit,
  input logic signed [scf_pkg::COORD_W-1:0] cross_x,
  input logic signed [scf_pkg::COORD_W-1:0] cross_y,
  input logic signed [scf_pkg::DIR_W-1:0]   a_dir_x,
  input logic signed [scf_pkg::DIR_W-1:0]   a_dir_y,
  input logic signed [scf_pkg::DIR_W-1:0]   b_dir_x,
  input logic signed [scf_pkg::DIR_W-1:0]   b_dir_y
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cross_x) && $stable(hit))
    else $error("stalled request changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> cross_x == '0 && cross_y == '0)
    else $error("crossing point set without a hit");

  a_hit_dirs: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (a_dir_x != '0 || a_dir_y != '0)
                      && (b_dir_x != '0 || b_dir_y != '0))
    else $error("hit with a degenerate segment");

endmodule

bind segment_pair_crossing scf_checker u_scf_checker (
  .clk, .rst, .out_valid, .out_stall, .hit, .cross_x, .cross_y,
  .a_dir_x, .a_dir_y, .b_dir_x, .b_dir_y
);

@@ test/crossing_checker.sv @@
// Checker for the segment pair crossing block: predicts each result and compares.
module crossing_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      wr_en,
  input  logic [scf_pkg::IDX_W-1:0]                 wr_index,
  input  logic [scf_pkg::CFG_W-1:0]                 wr_data,
  input  logic                                      in_valid,
  input  logic                                      in_stall,
  input  logic signed [scf_pkg::COORD_W-1:0]        a_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0]        a_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0]        a_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0]        a_end_y,
  input  logic signed [scf_pkg::COORD_W-1:0]        b_start_x,
  input  logic signed [scf_pkg::COORD_W-1:0]        b_start_y,
  input  logic signed [scf_pkg::COORD_W-1:0]        b_end_x,
  input  logic signed [scf_pkg::COORD_W-1:0]        b_end_y,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic                                      hit,
  input  logic signed [scf_pkg::COORD_W-1:0]        cross_x,
  input  logic signed [scf_pkg::COORD_W-1:0]        cross_y,
  input  logic signed [scf_pkg::DIR_W-1:0]          a_dir_x,
  input  logic signed [scf_pkg::DIR_W-1:0]          a_dir_y,
  input  logic signed [scf_pkg::DIR_W-1:0]          b_dir_x,
  input  logic signed [scf_pkg::DIR_W-1:0]          b_dir_y,
  output int                                        errors,
  output int                                        pending
);

  typedef struct {
    logic                               hit;
    logic signed [scf_pkg::COORD_W-1:0] cx;
    logic signed [scf_pkg::COORD_W-1:0] cy;
    logic signed [scf_pkg::DIR_W-1:0]   adx;
    logic signed [scf_pkg::DIR_W-1:0]   ady;
    logic signed [scf_pkg::DIR_W-1:0]   bdx;
    logic signed [scf_pkg::DIR_W-1:0]   bdy;
  } crossing_t;

  typedef logic signed [127:0] wide_t;

  logic [scf_pkg::MARGIN_W-1:0] margin_q;
  logic [scf_pkg::THR_W-1:0]    thr_q;
  crossing_t                    expected_q[$];

  assign pending = expected_q.size();

  function automatic bit param_inside(input wide_t n, input wide_t den,
                                      input logic [scf_pkg::MARGIN_W-1:0] m,
                                      output wide_t q);
    wide_t lo_lim;
    wide_t hi_lim;
    lo_lim = wide_t'({m, 16'd0});
    hi_lim = wide_t'({17'd65536 - {2'b0, m}, 16'd0});
    q = 0;
    if (n < 0 || n >= den) return 1'b0;
    q = (n <<< 32) / den;
    return q > lo_lim && q < hi_lim;
  endfunction

  function automatic logic signed [scf_pkg::COORD_W-1:0] crossing_axis(input wide_t start,
                                                                       input wide_t dir,
                                                                       input wide_t q);
    wide_t v;
    v = start + ((dir * q) >>> 32);
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[scf_pkg::COORD_W-1:0];
  endfunction

  function automatic crossing_t predict_crossing(
      input logic signed [scf_pkg::COORD_W-1:0] ax, ay, aex, aey, bx, by, bex, bey,
      input logic [scf_pkg::MARGIN_W-1:0] m, input logic [scf_pkg::THR_W-1:0] thr);
    wide_t wax, way, waex, waey, wbx, wby, wbex, wbey;
    wide_t dax, day, dbx, dby, ox, oy, den, tn, un, qt, qu;
    bit tin, uin;
    crossing_t r;
    wax = ax; way = ay; waex = aex; waey = aey;
    wbx = bx; wby = by; wbex = bex; wbey = bey;
    dax = waex - wax; day = waey - way;
    dbx = wbex - wbx; dby = wbey - wby;
    ox = wbx - wax; oy = wby - way;
    den = dax * dby - day * dbx;
    tn = ox * dby - oy * dbx;
    un = ox * day - oy * dax;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    r.hit = 1'b0;
    if (den >= $signed({96'd0, thr}) && den != 0) begin
      tin = param_inside(tn, den, m, qt);
      uin = param_inside(un, den, m, qu);
      r.hit = tin && uin;
    end
    r.cx = r.hit ? crossing_axis(wax, dax, qt) : '0;
    r.cy = r.hit ? crossing_axis(way, day, qt) : '0;
    r.adx = dax[scf_pkg::DIR_W-1:0]; r.ady = day[scf_pkg::DIR_W-1:0];
    r.bdx = dbx[scf_pkg::DIR_W-1:0]; r.bdy = dby[scf_pkg::DIR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      margin_q <= scf_pkg::MARGIN_RST;
      thr_q    <= scf_pkg::THR_RST;
    end else begin
      if (wr_en) begin
        if (wr_index == scf_pkg::REG_END_MARGIN) margin_q <= wr_data[scf_pkg::MARGIN_W-1:0];
        else if (wr_index == scf_pkg::REG_PAR_THR) thr_q <= wr_data[scf_pkg::THR_W-1:0];
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          predict_crossing(a_start_x, a_start_y, a_end_x, a_end_y,
                                           b_start_x, b_start_y, b_end_x, b_end_y,
                                           margin_q, thr_q));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (cross_x !== want.cx) report_mismatch("cross_x", cross_x, want.cx);
          if (cross_y !== want.cy) report_mismatch("cross_y", cross_y, want.cy);
          if (a_dir_x !== want.adx) report_mismatch("a_dir_x", a_dir_x, want.adx);
          if (a_dir_y !== want.ady) report_mismatch("a_dir_y", a_dir_y, want.ady);
          if (b_dir_x !== want.bdx) report_mismatch("b_dir_x", b_dir_x, want.bdx);
          if (b_dir_y !== want.bdy) report_mismatch("b_dir_y", b_dir_y, want.bdy);
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// Stimulus and verdict for the segment pair crossing block.
module tb_top;

  localparam int RANDOM_PAIRS = 1700;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [scf_pkg::COORD_W-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [scf_pkg::COORD_W-1:0] CMIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [scf_pkg::IDX_W-1:0] wr_index = '0;
  logic [scf_pkg::CFG_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [scf_pkg::COORD_W-1:0] a_start_x = '0, a_start_y = '0;
  logic signed [scf_pkg::COORD_W-1:0] a_end_x = '0, a_end_y = '0;
  logic signed [scf_pkg::COORD_W-1:0] b_start_x = '0, b_start_y = '0;
  logic signed [scf_pkg::COORD_W-1:0] b_end_x = '0, b_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic signed [scf_pkg::COORD_W-1:0] cross_x, cross_y;
  logic signed [scf_pkg::DIR_W-1:0] a_dir_x, a_dir_y, b_dir_x, b_dir_y;
  int errors, pending;
  int cycles = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  segment_pair_crossing dut (.*);
  crossing_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: alternate between free flow, random stalls and long holds
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ($urandom_range(0, 30) != 0);
    endcase
  end

  task automatic send_pair(input logic signed [scf_pkg::COORD_W-1:0] ax, ay, aex, aey,
                           input logic signed [scf_pkg::COORD_W-1:0] bx, by, bex, bey);
    in_valid = 1'b1;
    a_start_x = ax; a_start_y = ay; a_end_x = aex; a_end_y = aey;
    b_start_x = bx; b_start_y = by; b_end_x = bex; b_end_y = bey;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    // gap between bursts
    if ($urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [scf_pkg::IDX_W-1:0] idx,
                           input logic [scf_pkg::CFG_W-1:0] val);
    wr_en = 1'b1; wr_index = idx; wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  function automatic logic signed [scf_pkg::COORD_W-1:0] near(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_pair;
    logic signed [scf_pkg::COORD_W-1:0] c[8];
    int span;
    int k;
    span = ($urandom_range(0, 3) == 0) ? 32'h3fff_ffff : 32'h0010_0000;
    foreach (c[i]) c[i] = near(span);
    case ($urandom_range(0, 9))
      0: foreach (c[i]) c[i] = $urandom;
      1: begin
        // parallel: b direction is a multiple of a direction
        k = $urandom_range(1, 3);
        c[6] = c[4] + k * (c[2] - c[0]);
        c[7] = c[5] + k * (c[3] - c[1]);
      end
      2: begin
        // tiny denominator near the threshold
        c[2] = c[0] + $urandom_range(0, 2); c[3] = c[1] + $urandom_range(0, 2);
        c[6] = c[4] + $urandom_range(0, 2); c[7] = c[5] + $urandom_range(0, 2);
      end
      3: begin
        c[2] = c[0]; c[3] = c[1];
      end
      default: begin
        // crossing around a common point, mostly a hit
        c[2] = -c[0]; c[3] = -c[1]; c[6] = -c[4]; c[7] = -c[5];
      end
    endcase
    send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  task automatic directed_pairs;
    send_pair(0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0);
    send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
    send_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    send_pair(0, 0, 100, 0, 0, 5, 100, 5);
    send_pair(0, 0, 100, 0, 50, 0, 150, 0);
    send_pair(0, 0, 1, 0, 0, 0, 0, 1);
    send_pair(0, 0, 2, 1, 1, 0, 1, 1);
    send_pair(0, 0, 32'sh10000, 0, 32'sh51e, -10, 32'sh51e, 10);
    send_pair(0, 0, 32'sh10000, 0, 32'sh51f, -10, 32'sh51f, 10);
    send_pair(0, 0, 32'sh10000, 0, 32'shfae1, -10, 32'shfae1, 10);
    send_pair(0, 0, 32'sh10000, 0, 32'sh20000, -10, 32'sh20000, 10);
    send_pair(0, 0, 32'sh10000, 0, -32'sh100, -10, -32'sh100, 10);
    send_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
    send_pair(CMAX, 0, CMIN, 0, -1, CMAX, 1, CMIN);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    directed_pairs();
    drain();
    write_reg(scf_pkg::REG_END_MARGIN, 0);
    write_reg(scf_pkg::REG_PAR_THR, 0);
    directed_pairs();
    for (int i = 0; i < RANDOM_PAIRS / 4; i++) random_pair();
    // hold until every result is back once
    drain();
    write_reg(scf_pkg::REG_END_MARGIN, 32767);
    write_reg(scf_pkg::REG_PAR_THR, 32'hffffffff);
    for (int i = 0; i < RANDOM_PAIRS / 8; i++) random_pair();
    drain();
    write_reg(scf_pkg::REG_END_MARGIN, 1311);
    write_reg(scf_pkg::REG_PAR_THR, 4);
    for (int i = 0; i < RANDOM_PAIRS / 4; i++) random_pair();
    drain();
    write_reg(scf_pkg::REG_END_MARGIN, $urandom_range(0, 8000));
    write_reg(scf_pkg::REG_PAR_THR, $urandom_range(0, 64));
    for (int i = 0; i < RANDOM_PAIRS / 4; i++) random_pair();
    drain();
    write_reg(scf_pkg::REG_END_MARGIN, $urandom_range(0, 32767));
    write_reg(scf_pkg::REG_PAR_THR, $urandom);
    for (int i = 0; i < RANDOM_PAIRS / 8; i++) random_pair();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/scf_pkg.sv
design/scf_front.sv
design/scf_queue.sv
design/scf_back.sv
design/segment_pair_crossing.sv
design/scf_checker.sv
test/crossing_checker.sv
test/tb_top.sv
